@@ rtl/core/lcs_pkg.sv @@
// Package for the LCS line diff: sizes, opcodes, edit kinds, sequencer states and the engine status struct.
// Used by lcs_engine and lcs_line_diff; depends on nothing.
`timescale 1ns / 1ps
package lcs_pkg;
  localparam int unsigned MaxLinesDef = 32;
  localparam int unsigned TokenBitsDef = 32;

  typedef enum logic [1:0] {
    OP_APPEND_BASE  = 2'd0,
    OP_APPEND_OTHER = 2'd1,
    OP_RUN          = 2'd2,
    OP_CLEAR        = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_SAME = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_ADD  = 2'd2
  } edit_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_BT_RD,
    ST_BT_DEC,
    ST_BT_WR,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_HOLD
  } state_t;

  // Status the engine hands back to the top level.
  typedef struct packed {
    logic busy;
  } eng_status_t;
endpackage

@@ rtl/core/lcs_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module lcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/lcs_engine.sv @@
// Diff engine: sequence stores, LCS length table, edit stack and the sequencer over them.
// Depends on lcs_pkg and lcs_ram.
`timescale 1ns / 1ps
module lcs_engine #(
  parameter int unsigned MaxLines  = lcs_pkg::MaxLinesDef,
  parameter int unsigned TokenBits = lcs_pkg::TokenBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_token,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [5:0]          out_pos,
  output logic [4:0]          out_src,
  output logic [31:0]         out_token,
  output logic                out_last,
  output lcs_pkg::eng_status_t status
);
  import lcs_pkg::*;

  localparam int unsigned IW = (MaxLines > 1) ? $clog2(MaxLines) : 1;
  localparam int unsigned CW = $clog2(MaxLines + 1);
  localparam int unsigned TD = (MaxLines + 1) * (MaxLines + 1);
  localparam int unsigned TAW = $clog2(TD);
  localparam int unsigned SD = 2 * MaxLines;
  localparam int unsigned SW = $clog2(SD + 1);
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned EW = 2 + CW + IW + TokenBits;

  state_t state, state_next;
  logic [CW-1:0] base_count, other_count;
  logic [CW-1:0] ci, cj;
  logic [SW-1:0] sp;
  logic [5:0] left_len, up_len, diag_len, cur_len;
  logic [5:0] cell_up, cell_left;
  logic [1:0] phase;

  // Stores for the two sequences.
  logic b_we, o_we;
  logic [IW-1:0] b_raddr, o_raddr;
  logic [TokenBits-1:0] b_rdata, o_rdata, tok_m;
  assign tok_m = TokenBits'({32'd0, in_token} & {64{1'b1}} >> (64 - TokenBits));

  lcs_ram #(.Width(TokenBits), .Depth(MaxLines)) u_base (
    .clk, .we(b_we), .waddr(base_count[IW-1:0]), .wdata(tok_m),
    .raddr(b_raddr), .rdata(b_rdata));
  lcs_ram #(.Width(TokenBits), .Depth(MaxLines)) u_other (
    .clk, .we(o_we), .waddr(other_count[IW-1:0]), .wdata(tok_m),
    .raddr(o_raddr), .rdata(o_rdata));

  // Length table, row-major over (MaxLines+1) columns.
  logic t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [5:0] t_wdata, t_rdata, t_rd;
  logic [CW-1:0] rd_row, rd_col;
  logic rd_zero;
  lcs_ram #(.Width(6), .Depth(TD)) u_table (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata));

  // Edit stack.
  logic s_we;
  logic [SAW-1:0] s_raddr;
  logic [EW-1:0] s_wdata, s_rdata;
  lcs_ram #(.Width(EW), .Depth(SD)) u_stack (
    .clk, .we(s_we), .waddr(sp[SAW-1:0]), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));

  function automatic logic [TAW-1:0] taddr(input logic [CW-1:0] i, input logic [CW-1:0] j);
    return TAW'(i * (MaxLines + 1) + j);
  endfunction

  logic tok_eq;
  assign tok_eq = (b_rdata == o_rdata);

  // Edit record fields held between decide and write.
  edit_kind_t e_kind;
  logic [CW-1:0] e_pos;
  logic [IW-1:0] e_src;
  logic e_from_other;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      base_count <= '0;
      other_count <= '0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        unique case (opcode_t'(in_op))
          OP_APPEND_BASE:  if (base_count < CW'(MaxLines)) base_count <= base_count + 1'b1;
          OP_APPEND_OTHER: if (other_count < CW'(MaxLines)) other_count <= other_count + 1'b1;
          OP_CLEAR: begin
            base_count <= '0;
            other_count <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // The fill starts at the first cell; without a fill the backtrack starts at the end.
        if (base_count != 0 && other_count != 0) begin
          ci <= CW'(1);
          cj <= CW'(1);
        end else begin
          ci <= base_count;
          cj <= other_count;
        end
        sp <= '0;
        left_len <= '0;
        phase <= '0;
      end
      ST_FILL_RD: phase <= phase + 1'b1;
      ST_FILL_WR: begin
        left_len <= cur_len;
        phase <= '0;
        if (cj == other_count) begin
          // After the last cell the indices stay at the end for the backtrack.
          if (ci != base_count) begin
            cj <= CW'(1);
            ci <= ci + 1'b1;
            left_len <= '0;
          end
        end else begin
          cj <= cj + 1'b1;
        end
      end
      ST_BT_RD: phase <= phase + 1'b1;
      ST_BT_DEC: begin
        if (ci != 0 && cj != 0 && tok_eq) begin
          e_kind <= KIND_SAME; e_pos <= ci - 1'b1; e_src <= IW'(ci - 1'b1);
          e_from_other <= 1'b0; ci <= ci - 1'b1; cj <= cj - 1'b1;
        end else if (ci != 0 && (cj == 0 || cell_up >= cell_left)) begin
          e_kind <= KIND_DEL; e_pos <= ci - 1'b1; e_src <= IW'(ci - 1'b1);
          e_from_other <= 1'b0; ci <= ci - 1'b1;
        end else begin
          e_kind <= KIND_ADD; e_pos <= ci; e_src <= IW'(cj - 1'b1);
          e_from_other <= 1'b1; cj <= cj - 1'b1;
        end
        phase <= '0;
      end
      ST_BT_WR: sp <= sp + 1'b1;
      ST_OUT_HOLD: if (out_ready) sp <= sp - 1'b1;
      default: ;
    endcase
    // Table read data is registered; capture it by phase.
    if (state == ST_FILL_RD && phase == 2'd1) up_len <= t_rd;
    if (state == ST_FILL_RD && phase == 2'd2) diag_len <= t_rd;
    if (state == ST_BT_RD && phase == 2'd1) cell_up <= t_rd;
    if (state == ST_BT_RD && phase == 2'd2) cell_left <= t_rd;
  end

  // Output register loaded from the stack read.
  logic [TokenBits-1:0] e_tok_w;
  always_ff @(posedge clk) begin
    if (state == ST_OUT_WAIT) begin
      out_kind  <= s_rdata[EW-1 -: 2];
      out_pos   <= 6'(s_rdata[EW-3 -: CW]);
      out_src   <= 5'(s_rdata[TokenBits+IW-1 -: IW]);
      out_token <= 32'(s_rdata[TokenBits-1:0]);
      out_last  <= (sp == SW'(1));
    end
  end

  assign e_tok_w = e_from_other ? o_rdata : b_rdata;
  assign s_wdata = {e_kind, e_pos, e_src, e_tok_w};

  // Sequencer control.
  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    b_we = 1'b0;
    o_we = 1'b0;
    t_we = 1'b0;
    s_we = 1'b0;
    rd_row = ci - 1'b1;
    rd_col = cj;
    b_raddr = IW'(ci - 1'b1);
    o_raddr = IW'(cj - 1'b1);
    s_raddr = SAW'(sp - 1'b1);
    cur_len = tok_eq ? diag_len + 1'b1 : ((up_len > left_len) ? up_len : left_len);
    t_wdata = cur_len;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (opcode_t'(in_op))
            OP_APPEND_BASE:  b_we = (base_count < CW'(MaxLines));
            OP_APPEND_OTHER: o_we = (other_count < CW'(MaxLines));
            OP_RUN: begin
              if (base_count != 0 && other_count != 0) state_next = ST_FILL_RD;
              else if (base_count != 0 || other_count != 0) state_next = ST_BT_RD;
            end
            default: ;
          endcase
        end
      end
      ST_FILL_RD: begin
        // Phase 0 reads up, phase 1 reads diagonal, phase 2 captures it.
        if (phase == 2'd1) begin
          rd_row = ci - 1'b1;
          rd_col = cj - 1'b1;
        end
        if (phase == 2'd2) state_next = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        t_we = 1'b1;
        if (cj == other_count && ci == base_count) state_next = ST_BT_RD;
        else state_next = ST_FILL_RD;
      end
      ST_BT_RD: begin
        if (phase == 2'd1) begin
          rd_row = ci;
          rd_col = cj - 1'b1;
        end
        if (phase == 2'd2) state_next = ST_BT_DEC;
      end
      ST_BT_DEC: state_next = ST_BT_WR;
      ST_BT_WR: begin
        s_we = 1'b1;
        if (ci == 0 && cj == 0) state_next = ST_OUT_RD;
        else state_next = ST_BT_RD;
      end
      ST_OUT_RD: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: state_next = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) state_next = (sp == SW'(1)) ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign t_waddr = taddr(ci, cj);
  assign t_raddr = taddr(rd_row, rd_col);

  // Row 0 and column 0 are never written, so reads there are forced to zero.
  // A fresh table with undefined contents would otherwise leak into the fill.
  always_ff @(posedge clk) begin
    rd_zero <= (rd_row == '0) || (rd_col == '0);
  end
  assign t_rd = rd_zero ? 6'd0 : t_rdata;

  assign status.busy = (state != ST_IDLE);
endmodule

@@ rtl/core/lcs_line_diff.sv @@
// Top level of the LCS line diff: stream ports around the diff engine.
// Depends on lcs_pkg, lcs_engine and lcs_ram.
`timescale 1ns / 1ps
// Items carry an opcode and a line token. A run fills the (N+1)x(M+1) length table in one
// memory, reading the up and diagonal neighbours of each cell through its single read port and
// then writing the cell, then backtracks from the end cell onto an edit stack and emits the
// edits in forward order, each one held until it is taken by the output.
// A run with both sequences empty gives no item. Every item of a run's script is delivered
// before the next input item is taken.
module lcs_line_diff #(
  parameter int unsigned MaxLines  = lcs_pkg::MaxLinesDef,
  parameter int unsigned TokenBits = lcs_pkg::TokenBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // line_token [31:0]
  input  logic [1:0]  s_tuser,   // opcode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // base_position [5:0], source_index [10:6], edit_token [42:11]
  output logic [1:0]  m_tuser,   // edit_kind [1:0]
  output logic        m_tlast
);
  import lcs_pkg::*;

  eng_status_t status;
  logic [5:0] pos;
  logic [4:0] src;
  logic [31:0] tok;

  // Engine holds stores, table, stack and sequencer.
  lcs_engine #(.MaxLines(MaxLines), .TokenBits(TokenBits)) u_engine (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser), .in_token(s_tdata),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_kind(m_tuser), .out_pos(pos),
    .out_src(src), .out_token(tok), .out_last(m_tlast), .status(status));

  // Pack the result fields; unused status is folded into nothing visible.
  assign m_tdata = {5'd0, tok, src, pos} | {47'd0, 1'b0 & status.busy};
endmodule
